FILE: sv/rpwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpwc_pkg
// Shared types, codes and helpers of the ring prefetch window controller.
// ----------------------------------------------------------------------------
package rpwc_pkg;

    // default widths
    localparam int POS_WIDTH_DEF   = 48;
    localparam int COUNT_WIDTH_DEF = 20;

    // register reset values
    localparam logic [31:0] RING_BYTES_RST   = 32'd1048576;
    localparam logic [16:0] SECTOR_BYTES_RST = 17'd2048;
    localparam logic [31:0] KEEP_BACK_RST    = 32'd524288;
    localparam logic [31:0] MIN_FREE_RST     = 32'd16384;
    localparam logic [31:0] FWD_REACH_RST    = 32'd0;
    localparam logic [19:0] CHUNK_BYTES_RST  = 20'd8192;

    // register indexes (word address)
    localparam logic [2:0] REG_RING_BYTES   = 3'd0;
    localparam logic [2:0] REG_SECTOR_BYTES = 3'd1;
    localparam logic [2:0] REG_KEEP_BACK    = 3'd2;
    localparam logic [2:0] REG_MIN_FREE     = 3'd3;
    localparam logic [2:0] REG_FWD_REACH    = 3'd4;
    localparam logic [2:0] REG_CHUNK_BYTES  = 3'd5;

    // read stop codes
    localparam logic [1:0] STOP_COMPLETE   = 2'd0;
    localparam logic [1:0] STOP_SHORT_FILL = 2'd1;
    localparam logic [1:0] STOP_SHORT_END  = 2'd2;

    localparam logic [16:0] SECTOR_MAX = 17'd65536;

    typedef enum logic [2:0] {
        OP_PLAN_FILL  = 3'd0,
        OP_FILL_DONE  = 3'd1,
        OP_READ       = 3'd2,
        OP_SEEK       = 3'd3,
        OP_REPOSITION = 3'd4
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PF_FLUSH, S_PF_BACK, S_PF_USED, S_PF_RI2, S_PF_RI3, S_PF_POS,
        S_PF_SPACE, S_PF_CLAMP, S_PF_T, S_PF_TX, S_PF_CAND, S_PF_LOW,
        S_FD_RI1, S_FD_RI2, S_FD_RI3, S_FD_COMMIT,
        S_RD_CHK, S_RD_RI2, S_RD_RI3, S_RD_ROOM, S_RD_ADV, S_RD_DONE,
        S_SK_DIV, S_SK_DONE,
        S_RP,
        S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        C_NONE,
        C_ACCEPT,
        C_PF_FLUSH, C_PF_BACK, C_PF_USED, C_PF_POS, C_PF_SPACE, C_PF_CLAMP,
        C_PF_T, C_PF_TX, C_PF_CAND, C_PF_LOW,
        C_RI1_HIGH, C_RI2, C_RI3,
        C_FD_COMMIT,
        C_RD_CHK, C_RD_ROOM, C_RD_ADV, C_RD_DONE,
        C_SK_DIV, C_SK_DONE,
        C_RP,
        C_EMIT
    } t_cmd;

    // datapath status toward the controller
    typedef struct packed {
        logic       out_free;
        logic       pf_nofill;
        logic       rd_stop;
        logic       rd_zero;
        logic       div_last;
        logic       emit_last;
        logic [1:0] rd_n;
    } t_sts;

    // configuration registers
    typedef struct packed {
        logic [31:0] ring_bytes;
        logic [16:0] sector_bytes;
        logic [31:0] keep_back_bytes;
        logic [31:0] min_free_bytes;
        logic [31:0] forward_reach_bytes;
        logic [19:0] chunk_bytes;
    } t_cfg;

    // sector size with zero read as one and large values capped
    function automatic logic [16:0] f_eff_sector(input logic [16:0] s);
        logic [16:0] r;
        r = s;
        if (s == 17'd0) begin
            r = 17'd1;
        end else if (s > SECTOR_MAX) begin
            r = SECTOR_MAX;
        end
        return r;
    endfunction

    // largest fill request; zero chunk means four sectors
    function automatic logic [19:0] f_fill_limit(input logic [19:0] chunk,
                                                 input logic [16:0] sec);
        logic [19:0] r;
        r = chunk;
        if (chunk == 20'd0) begin
            r = {1'b0, sec, 2'b00};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/rpwc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpwc_ctrl
// Sequencer: walks each operation through its datapath steps and emits
// the result transfers one at a time.
// ----------------------------------------------------------------------------
module rpwc_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire        [2:0] i_operation,
    output logic             o_in_ready,
    input  rpwc_pkg::t_sts   i_sts,
    output rpwc_pkg::t_cmd   o_cmd
);

    rpwc_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpwc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpwc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_operation)
                        rpwc_pkg::OP_PLAN_FILL:  n_state = rpwc_pkg::S_PF_FLUSH;
                        rpwc_pkg::OP_FILL_DONE:  n_state = rpwc_pkg::S_FD_RI1;
                        rpwc_pkg::OP_READ:       n_state = rpwc_pkg::S_RD_CHK;
                        rpwc_pkg::OP_SEEK:       n_state = rpwc_pkg::S_SK_DIV;
                        rpwc_pkg::OP_REPOSITION: n_state = rpwc_pkg::S_RP;
                        default:                 n_state = rpwc_pkg::S_IDLE;
                    endcase
                end
            end
            rpwc_pkg::S_PF_FLUSH: n_state = rpwc_pkg::S_PF_BACK;
            rpwc_pkg::S_PF_BACK:  n_state = rpwc_pkg::S_PF_USED;
            rpwc_pkg::S_PF_USED:  n_state = rpwc_pkg::S_PF_RI2;
            rpwc_pkg::S_PF_RI2:   n_state = rpwc_pkg::S_PF_RI3;
            rpwc_pkg::S_PF_RI3:   n_state = rpwc_pkg::S_PF_POS;
            rpwc_pkg::S_PF_POS: begin
                n_state = i_sts.pf_nofill ? rpwc_pkg::S_EMIT : rpwc_pkg::S_PF_SPACE;
            end
            rpwc_pkg::S_PF_SPACE: n_state = rpwc_pkg::S_PF_CLAMP;
            rpwc_pkg::S_PF_CLAMP: n_state = rpwc_pkg::S_PF_T;
            rpwc_pkg::S_PF_T:     n_state = rpwc_pkg::S_PF_TX;
            rpwc_pkg::S_PF_TX:    n_state = rpwc_pkg::S_PF_CAND;
            rpwc_pkg::S_PF_CAND:  n_state = rpwc_pkg::S_PF_LOW;
            rpwc_pkg::S_PF_LOW:   n_state = rpwc_pkg::S_EMIT;
            rpwc_pkg::S_FD_RI1:   n_state = rpwc_pkg::S_FD_RI2;
            rpwc_pkg::S_FD_RI2:   n_state = rpwc_pkg::S_FD_RI3;
            rpwc_pkg::S_FD_RI3:   n_state = rpwc_pkg::S_FD_COMMIT;
            rpwc_pkg::S_FD_COMMIT: n_state = rpwc_pkg::S_EMIT;
            rpwc_pkg::S_RD_CHK: begin
                n_state = i_sts.rd_stop ? rpwc_pkg::S_RD_DONE : rpwc_pkg::S_RD_RI2;
            end
            rpwc_pkg::S_RD_RI2:   n_state = rpwc_pkg::S_RD_RI3;
            rpwc_pkg::S_RD_RI3:   n_state = rpwc_pkg::S_RD_ROOM;
            rpwc_pkg::S_RD_ROOM:  n_state = rpwc_pkg::S_RD_ADV;
            rpwc_pkg::S_RD_ADV: begin
                n_state = i_sts.rd_zero ? rpwc_pkg::S_RD_DONE : rpwc_pkg::S_RD_CHK;
            end
            rpwc_pkg::S_RD_DONE:  n_state = rpwc_pkg::S_EMIT;
            rpwc_pkg::S_SK_DIV: begin
                if (i_sts.div_last) begin
                    n_state = rpwc_pkg::S_SK_DONE;
                end
            end
            rpwc_pkg::S_SK_DONE:  n_state = rpwc_pkg::S_EMIT;
            rpwc_pkg::S_RP:       n_state = rpwc_pkg::S_EMIT;
            rpwc_pkg::S_EMIT: begin
                if (i_sts.out_free && i_sts.emit_last) begin
                    n_state = rpwc_pkg::S_IDLE;
                end
            end
            default: n_state = rpwc_pkg::S_IDLE;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd      = rpwc_pkg::C_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            rpwc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = rpwc_pkg::C_ACCEPT;
                end
            end
            rpwc_pkg::S_PF_FLUSH:  o_cmd = rpwc_pkg::C_PF_FLUSH;
            rpwc_pkg::S_PF_BACK:   o_cmd = rpwc_pkg::C_PF_BACK;
            rpwc_pkg::S_PF_USED:   o_cmd = rpwc_pkg::C_PF_USED;
            rpwc_pkg::S_PF_POS:    o_cmd = rpwc_pkg::C_PF_POS;
            rpwc_pkg::S_PF_SPACE:  o_cmd = rpwc_pkg::C_PF_SPACE;
            rpwc_pkg::S_PF_CLAMP:  o_cmd = rpwc_pkg::C_PF_CLAMP;
            rpwc_pkg::S_PF_T:      o_cmd = rpwc_pkg::C_PF_T;
            rpwc_pkg::S_PF_TX:     o_cmd = rpwc_pkg::C_PF_TX;
            rpwc_pkg::S_PF_CAND:   o_cmd = rpwc_pkg::C_PF_CAND;
            rpwc_pkg::S_PF_LOW:    o_cmd = rpwc_pkg::C_PF_LOW;
            rpwc_pkg::S_FD_RI1:    o_cmd = rpwc_pkg::C_RI1_HIGH;
            rpwc_pkg::S_PF_RI2, rpwc_pkg::S_FD_RI2, rpwc_pkg::S_RD_RI2: begin
                o_cmd = rpwc_pkg::C_RI2;
            end
            rpwc_pkg::S_PF_RI3, rpwc_pkg::S_FD_RI3, rpwc_pkg::S_RD_RI3: begin
                o_cmd = rpwc_pkg::C_RI3;
            end
            rpwc_pkg::S_FD_COMMIT: o_cmd = rpwc_pkg::C_FD_COMMIT;
            rpwc_pkg::S_RD_CHK:    o_cmd = rpwc_pkg::C_RD_CHK;
            rpwc_pkg::S_RD_ROOM:   o_cmd = rpwc_pkg::C_RD_ROOM;
            rpwc_pkg::S_RD_ADV:    o_cmd = rpwc_pkg::C_RD_ADV;
            rpwc_pkg::S_RD_DONE:   o_cmd = rpwc_pkg::C_RD_DONE;
            rpwc_pkg::S_SK_DIV:    o_cmd = rpwc_pkg::C_SK_DIV;
            rpwc_pkg::S_SK_DONE:   o_cmd = rpwc_pkg::C_SK_DONE;
            rpwc_pkg::S_RP:        o_cmd = rpwc_pkg::C_RP;
            rpwc_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd = rpwc_pkg::C_EMIT;
                end
            end
            default: o_cmd = rpwc_pkg::C_NONE;
        endcase
    end

    // checks
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == rpwc_pkg::C_EMIT) |-> i_sts.out_free)
        else $error("result loaded into an occupied output register");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == rpwc_pkg::C_EMIT && i_sts.emit_last) |=> (r_state == rpwc_pkg::S_IDLE))
        else $error("last result did not return to idle");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpwc_pkg::S_SK_DIV && i_sts.div_last) |=>
            (r_state == rpwc_pkg::S_SK_DONE))
        else $error("sector remainder did not finish");

    a_two_chunks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpwc_pkg::S_RD_CHK && i_sts.rd_n == 2'd2) |-> i_sts.rd_stop)
        else $error("read went past two chunks");

endmodule
`default_nettype wire

FILE: sv/rpwc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpwc_dp
// Datapath: window state, step temporaries, sector remainder unit, result
// slots and the output register.
// ----------------------------------------------------------------------------
module rpwc_dp #(
    parameter int POS_WIDTH   = rpwc_pkg::POS_WIDTH_DEF,
    parameter int COUNT_WIDTH = rpwc_pkg::COUNT_WIDTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  rpwc_pkg::t_cmd         i_cmd,
    output rpwc_pkg::t_sts         o_sts,
    input  rpwc_pkg::t_cfg         i_cfg,
    input  wire  [POS_WIDTH-1:0]   i_position,
    input  wire  [COUNT_WIDTH-1:0] i_count,
    input  wire                    i_at_end,
    input  wire                    i_out_ready,
    output logic                   o_out_valid,
    output logic [31:0]            o_ring_pos,
    output logic [COUNT_WIDTH-1:0] o_length,
    output logic                   o_wrap_copy,
    output logic                   o_seek_needed,
    output logic [POS_WIDTH-1:0]   o_seek_pos,
    output logic [15:0]            o_skip_bytes,
    output logic [1:0]             o_stop_status,
    output logic [31:0]            o_fill_level,
    output logic                   o_last
);

    localparam int W   = POS_WIDTH;
    localparam int CW  = COUNT_WIDTH;
    localparam int DCW = $clog2(W);
    localparam logic [W-1:0]   POS_MAX   = {W{1'b1}};
    localparam logic [DCW-1:0] DIV_LAST  = DCW'(W - 1);

    // window state
    logic [W-1:0]  r_wlow, r_whigh, r_origin, r_read;
    logic          r_ended;

    // step temporaries
    logic [W-1:0]  r_p, r_rd, r_newb, r_ri_d, r_ri_e, r_cand, r_avail, r_divsh;
    logic [CW-1:0] r_cnt, r_size;
    logic          r_atend, r_ri_ge, r_tgt, r_hascand;
    logic [31:0]   r_back, r_pos, r_space, r_room;
    logic [W:0]    r_used, r_t, r_tx;
    logic [1:0]    r_rstat, r_n;
    logic          r_k, r_nlast;
    logic [16:0]   r_rem;
    logic [DCW-1:0] r_divcnt;
    logic          r_ov;

    // result slots
    logic [31:0]   r_s_pos  [2];
    logic [CW-1:0] r_s_len  [2];
    logic          r_s_wrap [2];
    logic          r_s_sk   [2];
    logic [W-1:0]  r_s_spos [2];
    logic [15:0]   r_s_skip [2];
    logic [1:0]    r_s_st   [2];

    // derived config
    logic [16:0]   c_sec;
    logic [19:0]   c_lim;
    logic [W-1:0]  c_ringw;
    logic [W:0]    c_ringw1;

    assign c_sec    = rpwc_pkg::f_eff_sector(i_cfg.sector_bytes);
    assign c_lim    = rpwc_pkg::f_fill_limit(i_cfg.chunk_bytes, c_sec);
    assign c_ringw  = W'(i_cfg.ring_bytes);
    assign c_ringw1 = (W+1)'(i_cfg.ring_bytes);

    // ring index, first step operand and difference
    logic [W-1:0] c_ri_op;
    logic         c_ri_ge;
    logic [W-1:0] c_ri_d;
    assign c_ri_op = (i_cmd == rpwc_pkg::C_RI1_HIGH || i_cmd == rpwc_pkg::C_PF_USED)
                     ? r_whigh : r_rd;
    assign c_ri_ge = (c_ri_op >= r_origin);
    assign c_ri_d  = c_ri_ge ? (c_ri_op - r_origin) : (r_origin - c_ri_op);

    // ring index, one correction by the ring size
    logic [W-1:0] c_ri_e;
    always_comb begin
        if (r_ri_ge) begin
            c_ri_e = (r_ri_d >= c_ringw) ? (r_ri_d - c_ringw) : r_ri_d;
        end else begin
            c_ri_e = (r_ri_d <= c_ringw) ? (c_ringw - r_ri_d) : c_ringw;
        end
    end

    // plan fill flush test
    logic [W-1:0] c_fw;
    logic         c_flush;
    assign c_fw    = r_rd - r_whigh;
    assign c_flush = (r_rd < r_wlow) ||
                     ((r_rd > r_whigh) && (c_fw >= W'(i_cfg.forward_reach_bytes)));

    // kept bytes behind the read position
    logic [W-1:0] c_bk;
    assign c_bk = (r_rd > r_wlow) ? (r_rd - r_wlow) : '0;

    // no fill when free space under the limit
    assign o_sts.pf_nofill = (r_used > c_ringw1) ||
                             ((i_cfg.ring_bytes - r_used[31:0]) < i_cfg.min_free_bytes);

    // fill size clamp
    logic [31:0] c_s1, c_s2;
    logic        c_wrap;
    always_comb begin
        c_wrap = 1'b0;
        c_s1   = r_space;
        if (r_space > r_room) begin
            if (r_room >= 32'(c_sec)) begin
                c_s1 = r_room;
            end else begin
                c_s1   = 32'(c_sec);
                c_wrap = 1'b1;
            end
        end
        c_s2 = (c_s1 > 32'(c_lim)) ? 32'(c_lim) : c_s1;
    end

    // window floor candidate
    logic [W+1:0] c_csum;
    assign c_csum = (W+2)'(r_rd) + (W+2)'(r_tx);

    // read stop tests
    logic       c_size0, c_outwin, c_n2;
    logic [1:0] c_stat;
    assign c_size0  = (r_size == '0);
    assign c_outwin = (r_rd >= r_whigh) || (r_rd < r_wlow);
    assign c_n2     = (r_n == 2'd2);
    always_comb begin
        if (c_size0) begin
            c_stat = rpwc_pkg::STOP_COMPLETE;
        end else if (c_outwin) begin
            c_stat = r_ended ? rpwc_pkg::STOP_SHORT_END : rpwc_pkg::STOP_SHORT_FILL;
        end else begin
            c_stat = rpwc_pkg::STOP_SHORT_FILL;
        end
    end
    assign o_sts.rd_stop = c_size0 || c_outwin || c_n2;

    // chunk length limited by the bytes wanted
    logic [CW-1:0] c_a2;
    assign c_a2          = (r_avail > W'(r_size)) ? r_size : r_avail[CW-1:0];
    assign o_sts.rd_zero = (c_a2 == '0);

    // sector remainder step
    logic [17:0] c_rs;
    logic [17:0] c_rs2;
    assign c_rs  = {r_rem, r_divsh[W-1]};
    assign c_rs2 = (c_rs >= 18'(c_sec)) ? (c_rs - 18'(c_sec)) : c_rs;

    // bytes ahead of the read position
    logic [W-1:0]  c_lvl_d;
    logic [31:0]   c_level;
    always_comb begin
        c_lvl_d = (r_whigh > r_read) ? (r_whigh - r_read) : '0;
        c_level = (c_lvl_d > W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : c_lvl_d[31:0];
    end

    logic [32:0] c_fd_end;
    assign c_fd_end = 33'(r_pos) + 33'(r_cnt);

    assign o_sts.out_free  = !r_ov || i_out_ready;
    assign o_sts.div_last  = (r_divcnt == DIV_LAST);
    assign o_sts.emit_last = (r_k == r_nlast);
    assign o_sts.rd_n      = r_n;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlow   <= '0;
            r_whigh  <= '0;
            r_origin <= '0;
            r_read   <= '0;
            r_ended  <= 1'b0;
            r_n      <= '0;
            r_k      <= 1'b0;
            r_nlast  <= 1'b0;
            r_divcnt <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cmd == rpwc_pkg::C_EMIT) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (i_cmd)
                rpwc_pkg::C_ACCEPT: begin
                    r_n      <= '0;
                    r_k      <= 1'b0;
                    r_nlast  <= 1'b0;
                    r_divcnt <= '0;
                end
                rpwc_pkg::C_PF_FLUSH: begin
                    if (c_flush) begin
                        r_wlow   <= r_rd;
                        r_whigh  <= r_rd;
                        r_origin <= r_rd;
                    end
                end
                rpwc_pkg::C_PF_LOW: begin
                    if (r_hascand && r_wlow < r_cand) begin
                        r_wlow <= r_cand;
                    end
                end
                rpwc_pkg::C_FD_COMMIT: begin
                    r_ended <= (r_cnt == '0);
                    r_whigh <= r_whigh + W'(r_cnt);
                    if (c_fd_end >= 33'(i_cfg.ring_bytes)) begin
                        r_origin <= r_origin + c_ringw;
                    end
                end
                rpwc_pkg::C_RD_ADV: begin
                    if (!o_sts.rd_zero) begin
                        r_n <= r_n + 2'd1;
                    end
                end
                rpwc_pkg::C_RD_DONE: begin
                    r_read <= r_rd;
                    if (r_n != 2'd0) begin
                        r_nlast <= r_n[1];
                    end
                end
                rpwc_pkg::C_SK_DIV: begin
                    r_divcnt <= r_divcnt + DCW'(1);
                end
                rpwc_pkg::C_SK_DONE: begin
                    r_read  <= r_p - W'(r_rem);
                    r_ended <= 1'b0;
                end
                rpwc_pkg::C_RP: begin
                    r_read   <= r_p;
                    r_ended  <= r_atend;
                    r_wlow   <= r_p;
                    r_whigh  <= r_p;
                    r_origin <= r_p;
                end
                rpwc_pkg::C_EMIT: begin
                    r_k <= ~r_k;
                end
                default: ;
            endcase
        end
    end

    // step temporaries and result slots
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            rpwc_pkg::C_ACCEPT: begin
                r_p     <= i_position;
                r_cnt   <= i_count;
                r_atend <= i_at_end;
                r_rd    <= r_read;
                r_size  <= i_count;
                r_rem   <= '0;
                r_divsh <= i_position;
                for (int i = 0; i < 2; i++) begin
                    r_s_pos[i]  <= '0;
                    r_s_len[i]  <= '0;
                    r_s_wrap[i] <= 1'b0;
                    r_s_sk[i]   <= 1'b0;
                    r_s_spos[i] <= '0;
                    r_s_skip[i] <= '0;
                    r_s_st[i]   <= '0;
                end
            end
            rpwc_pkg::C_PF_FLUSH: begin
                if (c_flush) begin
                    r_s_sk[0]   <= 1'b1;
                    r_s_spos[0] <= r_rd;
                end
            end
            rpwc_pkg::C_PF_BACK: begin
                r_back <= (c_bk > W'(i_cfg.keep_back_bytes)) ? i_cfg.keep_back_bytes
                                                             : c_bk[31:0];
                r_newb <= (r_whigh > r_rd) ? (r_whigh - r_rd) : '0;
            end
            rpwc_pkg::C_PF_USED: begin
                r_used  <= {1'b0, r_newb} + (W+1)'(r_back);
                r_ri_ge <= c_ri_ge;
                r_ri_d  <= c_ri_d;
            end
            rpwc_pkg::C_RI1_HIGH, rpwc_pkg::C_RD_CHK: begin
                r_ri_ge <= c_ri_ge;
                r_ri_d  <= c_ri_d;
                if (i_cmd == rpwc_pkg::C_RD_CHK) begin
                    r_rstat <= c_stat;
                    r_avail <= r_whigh - r_rd;
                end
            end
            rpwc_pkg::C_RI2: begin
                r_ri_e <= c_ri_e;
            end
            rpwc_pkg::C_RI3: begin
                r_pos <= (r_ri_e >= c_ringw) ? 32'd0 : r_ri_e[31:0];
            end
            rpwc_pkg::C_PF_POS: begin
                r_s_pos[0] <= r_pos;
            end
            rpwc_pkg::C_PF_SPACE: begin
                r_space <= i_cfg.ring_bytes - r_used[31:0];
                r_room  <= i_cfg.ring_bytes - r_pos;
            end
            rpwc_pkg::C_PF_CLAMP: begin
                r_space     <= c_s2;
                r_s_len[0]  <= CW'(c_s2);
                r_s_wrap[0] <= c_wrap;
            end
            rpwc_pkg::C_PF_T: begin
                r_t <= (W+1)'(r_space) + {1'b0, r_newb};
            end
            rpwc_pkg::C_PF_TX: begin
                r_tgt <= (r_t > c_ringw1);
                r_tx  <= (r_t > c_ringw1) ? (r_t - c_ringw1) : (c_ringw1 - r_t);
            end
            rpwc_pkg::C_PF_CAND: begin
                if (r_tgt) begin
                    r_hascand <= 1'b1;
                    r_cand    <= (c_csum > (W+2)'(POS_MAX)) ? POS_MAX : c_csum[W-1:0];
                end else begin
                    r_hascand <= ((W+1)'(r_rd) > r_tx);
                    r_cand    <= r_rd - r_tx[W-1:0];
                end
            end
            rpwc_pkg::C_FD_COMMIT: begin
                r_s_pos[0] <= r_pos;
                r_s_len[0] <= r_cnt;
            end
            rpwc_pkg::C_RD_ROOM: begin
                if (r_avail > W'(i_cfg.ring_bytes - r_pos)) begin
                    r_avail <= W'(i_cfg.ring_bytes - r_pos);
                end
            end
            rpwc_pkg::C_RD_ADV: begin
                if (o_sts.rd_zero) begin
                    r_rstat <= rpwc_pkg::STOP_SHORT_FILL;
                end else begin
                    r_s_pos[r_n[0]] <= r_pos;
                    r_s_len[r_n[0]] <= c_a2;
                    r_rd            <= r_rd + W'(c_a2);
                    r_size          <= r_size - c_a2;
                end
            end
            rpwc_pkg::C_RD_DONE: begin
                if (r_n == 2'd2) begin
                    r_s_st[1] <= r_rstat;
                end else begin
                    r_s_st[0] <= r_rstat;
                end
            end
            rpwc_pkg::C_SK_DIV: begin
                r_rem   <= c_rs2[16:0];
                r_divsh <= {r_divsh[W-2:0], 1'b0};
            end
            rpwc_pkg::C_SK_DONE: begin
                r_s_spos[0] <= r_p - W'(r_rem);
                r_s_skip[0] <= r_rem[15:0];
            end
            rpwc_pkg::C_RP: begin
                r_s_spos[0] <= r_p;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd == rpwc_pkg::C_EMIT) begin
            o_ring_pos    <= r_s_pos[r_k];
            o_length      <= r_s_len[r_k];
            o_wrap_copy   <= r_s_wrap[r_k];
            o_seek_needed <= r_s_sk[r_k];
            o_seek_pos    <= r_s_spos[r_k];
            o_skip_bytes  <= r_s_skip[r_k];
            o_stop_status <= r_s_st[r_k];
            o_fill_level  <= c_level;
            o_last        <= (r_k == r_nlast);
        end
    end

    assign o_out_valid = r_ov;

endmodule
`default_nettype wire

FILE: sv/ring_prefetch_window_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Each operation runs through its datapath steps from the accept cycle to
// the first result; a read repeats its steps for each chunk, the sector
// divider of a seek yields one remainder bit per cycle, and every result
// then needs one transfer.
// Throughput: one operation at a time; the next is taken when the last
// result has been loaded into the output register.
// Reset: synchronous active low; window, origin, read position and end
// flag clear to zero, registers take their documented defaults.
// ----------------------------------------------------------------------------
// ring_prefetch_window_controller
// Bookkeeping of a ring prefetch cache: fill planning, fill commit, chunked
// reads, sector-aligned seek and reposition, with an APB register port.
// ----------------------------------------------------------------------------
module ring_prefetch_window_controller #(
    parameter int POS_WIDTH   = rpwc_pkg::POS_WIDTH_DEF,
    parameter int COUNT_WIDTH = rpwc_pkg::COUNT_WIDTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // register port
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [4:0]             paddr,
    input  wire  [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // operation channel
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire  [2:0]             i_operation,
    input  wire  [POS_WIDTH-1:0]   i_position,
    input  wire  [COUNT_WIDTH-1:0] i_count,
    input  wire                    i_at_end,
    // result channel
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output logic [31:0]            o_ring_pos,
    output logic [COUNT_WIDTH-1:0] o_length,
    output logic                   o_wrap_copy,
    output logic                   o_seek_needed,
    output logic [POS_WIDTH-1:0]   o_seek_pos,
    output logic [15:0]            o_skip_bytes,
    output logic [1:0]             o_stop_status,
    output logic [31:0]            o_fill_level,
    output logic                   o_last
);

    rpwc_pkg::t_cfg r_cfg;
    rpwc_pkg::t_cmd w_cmd;
    rpwc_pkg::t_sts w_sts;
    logic           w_wr;
    logic [2:0]     w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring_bytes          <= rpwc_pkg::RING_BYTES_RST;
            r_cfg.sector_bytes        <= rpwc_pkg::SECTOR_BYTES_RST;
            r_cfg.keep_back_bytes     <= rpwc_pkg::KEEP_BACK_RST;
            r_cfg.min_free_bytes      <= rpwc_pkg::MIN_FREE_RST;
            r_cfg.forward_reach_bytes <= rpwc_pkg::FWD_REACH_RST;
            r_cfg.chunk_bytes         <= rpwc_pkg::CHUNK_BYTES_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                rpwc_pkg::REG_RING_BYTES:   r_cfg.ring_bytes          <= pwdata;
                rpwc_pkg::REG_SECTOR_BYTES: r_cfg.sector_bytes        <= pwdata[16:0];
                rpwc_pkg::REG_KEEP_BACK:    r_cfg.keep_back_bytes     <= pwdata;
                rpwc_pkg::REG_MIN_FREE:     r_cfg.min_free_bytes      <= pwdata;
                rpwc_pkg::REG_FWD_REACH:    r_cfg.forward_reach_bytes <= pwdata;
                rpwc_pkg::REG_CHUNK_BYTES:  r_cfg.chunk_bytes         <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_idx)
            rpwc_pkg::REG_RING_BYTES:   prdata = r_cfg.ring_bytes;
            rpwc_pkg::REG_SECTOR_BYTES: prdata = 32'(r_cfg.sector_bytes);
            rpwc_pkg::REG_KEEP_BACK:    prdata = r_cfg.keep_back_bytes;
            rpwc_pkg::REG_MIN_FREE:     prdata = r_cfg.min_free_bytes;
            rpwc_pkg::REG_FWD_REACH:    prdata = r_cfg.forward_reach_bytes;
            rpwc_pkg::REG_CHUNK_BYTES:  prdata = 32'(r_cfg.chunk_bytes);
            default:                    prdata = 32'd0;
        endcase
    end

    rpwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rpwc_dp #(
        .POS_WIDTH   (POS_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg         (r_cfg),
        .i_position    (i_position),
        .i_count       (i_count),
        .i_at_end      (i_at_end),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_ring_pos    (o_ring_pos),
        .o_length      (o_length),
        .o_wrap_copy   (o_wrap_copy),
        .o_seek_needed (o_seek_needed),
        .o_seek_pos    (o_seek_pos),
        .o_skip_bytes  (o_skip_bytes),
        .o_stop_status (o_stop_status),
        .o_fill_level  (o_fill_level),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ring prefetch window controller: a scoreboard
// class tracks the window bookkeeping and checks every result field, while
// plain tasks drive fill, read, seek and reposition traffic under random
// idling on both channels across several register settings.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [63:0] POS_MASK = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] CNT_MASK = 64'h0000_0000_000F_FFFF;

    typedef struct {
        bit [31:0] ring_pos;
        bit [19:0] length;
        bit        wrap_copy;
        bit        seek_needed;
        bit [47:0] seek_pos;
        bit [15:0] skip_bytes;
        bit [1:0]  stop_status;
        bit [31:0] fill_level;
        bit        last;
    } t_window_result;

    // Window bookkeeping predictor and expected-result store
    class window_scoreboard;
        bit [63:0] ring_sz, sector_sz, keep_back, min_free, reach, chunk_sz;
        bit [63:0] win_lo, win_hi, origin, read_pos;
        bit        at_eos;
        bit [63:0] planned_len;
        bit        fill_pending;
        t_window_result awaited[$];
        int        errors;
        int        checked;

        function new();
            ring_sz = 1048576; sector_sz = 2048; keep_back = 524288;
            min_free = 16384; reach = 0; chunk_sz = 8192;
            win_lo = 0; win_hi = 0; origin = 0; read_pos = 0; at_eos = 0;
            fill_pending = 0; planned_len = 0; errors = 0; checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, bit [63:0] v);
            case (idx)
                rpwc_pkg::REG_RING_BYTES:   ring_sz   = v & 64'hFFFF_FFFF;
                rpwc_pkg::REG_SECTOR_BYTES: sector_sz = v & 64'h1_FFFF;
                rpwc_pkg::REG_KEEP_BACK:    keep_back = v & 64'hFFFF_FFFF;
                rpwc_pkg::REG_MIN_FREE:     min_free  = v & 64'hFFFF_FFFF;
                rpwc_pkg::REG_FWD_REACH:    reach     = v & 64'hFFFF_FFFF;
                rpwc_pkg::REG_CHUNK_BYTES:  chunk_sz  = v & CNT_MASK;
                default: ;
            endcase
        endfunction

        function bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
            bit [63:0] s;
            s = a + b;
            return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
        endfunction

        function bit [63:0] sector_eff();
            if (sector_sz == 0) return 1;
            return (sector_sz > 65536) ? 65536 : sector_sz;
        endfunction

        function bit [63:0] ring_slot(bit [63:0] p);
            bit [63:0] d, e;
            if (p >= origin) begin
                d = p - origin;
                if (d >= ring_sz) d -= ring_sz;
            end else begin
                e = origin - p;
                d = (e <= ring_sz) ? ring_sz - e : ring_sz;
            end
            if (d >= ring_sz) d = 0;
            return d;
        endfunction

        function bit [31:0] ahead_bytes();
            bit [63:0] l;
            l = (win_hi > read_pos) ? win_hi - read_pos : 0;
            return (l > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : l[31:0];
        endfunction

        function void push(bit [63:0] rp, bit [63:0] len, bit wrap, bit sk,
                           bit [63:0] spos, bit [63:0] skip, bit [1:0] st,
                           bit lst);
            t_window_result r;
            r.ring_pos = rp[31:0];
            r.length = len[19:0];
            r.wrap_copy = wrap;
            r.seek_needed = sk;
            r.seek_pos = spos[47:0];
            r.skip_bytes = skip[15:0];
            r.stop_status = st;
            r.fill_level = ahead_bytes();
            r.last = lst;
            awaited.push_back(r);
        endfunction

        function void plan_fill();
            bit [63:0] rd, back, newb, used, pos, space, room, lim, t, cand, b2, sec;
            bit sk, wrap;
            rd = read_pos; sec = sector_eff(); sk = 0; wrap = 0;
            // flush on backward jump or forward jump beyond reach
            if (rd < win_lo || rd > win_hi) begin
                if (rd < win_lo || rd - win_hi >= reach) begin
                    win_lo = rd; win_hi = rd; origin = rd; sk = 1;
                end
            end
            back = (rd > win_lo) ? rd - win_lo : 0;
            if (back > keep_back) back = keep_back;
            newb = (win_hi > rd) ? win_hi - rd : 0;
            used = sat_sum(newb, back);
            pos = ring_slot(win_hi);
            if (used > ring_sz || ring_sz - used < min_free) begin
                push(pos, 0, 0, sk, sk ? rd : 0, 0, rpwc_pkg::STOP_COMPLETE, 1);
                planned_len = 0;
                return;
            end
            space = ring_sz - used;
            room = ring_sz - pos;
            if (space > room) begin
                if (room >= sec) space = room;
                else begin
                    space = sec;
                    wrap = 1;
                end
            end
            lim = chunk_sz ? chunk_sz : 4 * sec;
            if (space > lim) space = lim;
            // raise the floor so the new fill does not overwrite kept bytes
            t = sat_sum(space, newb);
            if (t > ring_sz) begin
                cand = sat_sum(rd, t - ring_sz);
                if (cand > POS_MASK) cand = POS_MASK;
                if (win_lo < cand) win_lo = cand;
            end else begin
                b2 = ring_sz - t;
                if (rd > b2 && win_lo < rd - b2) win_lo = rd - b2;
            end
            push(pos, space, wrap, sk, sk ? rd : 0, 0, rpwc_pkg::STOP_COMPLETE, 1);
            planned_len = space;
        endfunction

        function void fill_done(bit [63:0] len);
            bit [63:0] pos;
            pos = ring_slot(win_hi);
            at_eos = (len == 0);
            win_hi = (win_hi + len) & POS_MASK;
            if (pos + len >= ring_sz) origin = (origin + ring_sz) & POS_MASK;
            push(pos, len, 0, 0, 0, 0, rpwc_pkg::STOP_COMPLETE, 1);
        endfunction

        function void read_chunks(bit [63:0] size);
            bit [63:0] rd, avail, pos, room;
            bit [63:0] cpos [2];
            bit [63:0] clen [2];
            bit [1:0]  st;
            int n;
            rd = read_pos; n = 0;
            forever begin
                if (size == 0) begin st = rpwc_pkg::STOP_COMPLETE; break; end
                if (rd >= win_hi || rd < win_lo) begin
                    st = at_eos ? rpwc_pkg::STOP_SHORT_END : rpwc_pkg::STOP_SHORT_FILL;
                    break;
                end
                if (n == 2) begin st = rpwc_pkg::STOP_SHORT_FILL; break; end
                avail = win_hi - rd;
                pos = ring_slot(rd);
                room = ring_sz - pos;
                if (avail > room) avail = room;
                if (avail > size) avail = size;
                if (avail == 0) begin st = rpwc_pkg::STOP_SHORT_FILL; break; end
                cpos[n] = pos; clen[n] = avail; n++;
                rd += avail; size -= avail;
            end
            read_pos = rd & POS_MASK;
            if (n == 0) push(0, 0, 0, 0, 0, 0, st, 1);
            for (int k = 0; k < n; k++)
                push(cpos[k], clen[k], 0, 0, 0, 0,
                     (k == n - 1) ? st : rpwc_pkg::STOP_COMPLETE, k == n - 1);
        endfunction

        // note an accepted operation and queue what it should produce
        function void note_op(bit [2:0] op, bit [47:0] p, bit [19:0] cnt, bit ae);
            bit [63:0] aligned;
            case (op)
                rpwc_pkg::OP_PLAN_FILL: begin plan_fill(); fill_pending = 1; end
                rpwc_pkg::OP_FILL_DONE: begin fill_done(64'(cnt)); fill_pending = 0; end
                rpwc_pkg::OP_READ: read_chunks(64'(cnt));
                rpwc_pkg::OP_SEEK: begin
                    aligned = 64'(p) - 64'(p) % sector_eff();
                    read_pos = aligned;
                    at_eos = 0;
                    push(0, 0, 0, 0, aligned, 64'(p) - aligned, rpwc_pkg::STOP_COMPLETE, 1);
                end
                rpwc_pkg::OP_REPOSITION: begin
                    read_pos = 64'(p); at_eos = ae;
                    win_lo = 64'(p); win_hi = 64'(p); origin = 64'(p);
                    push(0, 0, 0, 0, 64'(p), 0, rpwc_pkg::STOP_COMPLETE, 1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_window_result a);
            t_window_result e;
            checked++;
            if (awaited.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (a.ring_pos != e.ring_pos) begin
                $error("ring_pos exp %h act %h", e.ring_pos, a.ring_pos); errors++;
            end
            if (a.length != e.length) begin
                $error("length exp %h act %h", e.length, a.length); errors++;
            end
            if (a.wrap_copy != e.wrap_copy) begin
                $error("wrap_copy exp %h act %h", e.wrap_copy, a.wrap_copy); errors++;
            end
            if (a.seek_needed != e.seek_needed) begin
                $error("seek_needed exp %h act %h", e.seek_needed, a.seek_needed);
                errors++;
            end
            if (a.seek_pos != e.seek_pos) begin
                $error("seek_pos exp %h act %h", e.seek_pos, a.seek_pos); errors++;
            end
            if (a.skip_bytes != e.skip_bytes) begin
                $error("skip_bytes exp %h act %h", e.skip_bytes, a.skip_bytes); errors++;
            end
            if (a.stop_status != e.stop_status) begin
                $error("stop_status exp %h act %h", e.stop_status, a.stop_status);
                errors++;
            end
            if (a.fill_level != e.fill_level) begin
                $error("fill_level exp %h act %h", e.fill_level, a.fill_level); errors++;
            end
            if (a.last != e.last) begin
                $error("last exp %h act %h", e.last, a.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        i_in_valid, o_in_ready;
    logic [2:0]  i_operation;
    logic [47:0] i_position;
    logic [19:0] i_count;
    logic        i_at_end;
    logic        o_out_valid, i_out_ready;
    logic [31:0] o_ring_pos;
    logic [19:0] o_length;
    logic        o_wrap_copy, o_seek_needed;
    logic [47:0] o_seek_pos;
    logic [15:0] o_skip_bytes;
    logic [1:0]  o_stop_status;
    logic [31:0] o_fill_level;
    logic        o_last;

    window_scoreboard sb;
    bit calm;        // no idling in the closing part
    bit stall_done;

    ring_prefetch_window_controller dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .i_in_valid, .o_in_ready, .i_operation, .i_position, .i_count,
        .i_at_end, .o_out_valid, .i_out_ready, .o_ring_pos, .o_length,
        .o_wrap_copy, .o_seek_needed, .o_seek_pos, .o_skip_bytes,
        .o_stop_status, .o_fill_level, .o_last
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // register write: setup then access cycle
    task automatic reg_write(logic [2:0] idx, bit [31:0] v);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = v;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
        sb.set_reg(idx, 64'(v));
    endtask

    // one operation transfer on the input channel
    task automatic send_op(bit [2:0] op, bit [47:0] p, bit [19:0] cnt, bit ae);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid = 0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid = 1; i_operation = op; i_position = p; i_count = cnt; i_at_end = ae;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_op(op, p, cnt, ae);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic set_phase(bit [31:0] rb, bit [31:0] sec, bit [31:0] kb,
                             bit [31:0] mf, bit [31:0] fr, bit [31:0] ch);
        drain();
        reg_write(rpwc_pkg::REG_RING_BYTES, rb);
        reg_write(rpwc_pkg::REG_SECTOR_BYTES, sec);
        reg_write(rpwc_pkg::REG_KEEP_BACK, kb);
        reg_write(rpwc_pkg::REG_MIN_FREE, mf);
        reg_write(rpwc_pkg::REG_FWD_REACH, fr);
        reg_write(rpwc_pkg::REG_CHUNK_BYTES, ch);
    endtask

    // random traffic, mostly plan/fill/read cycles with random content
    task automatic random_ops(int n);
        bit [2:0]  op;
        bit [47:0] p;
        bit [19:0] cnt;
        bit [63:0] span;
        int sel, done;
        done = 0;
        while (done < n) begin
            sel = $urandom_range(0, 99);
            p = 48'({$urandom(), $urandom()});
            cnt = 20'($urandom());
            if (sb.fill_pending && sel < 80) begin
                op = rpwc_pkg::OP_FILL_DONE;
                if ($urandom_range(0, 19) == 0) cnt = 0;
                else if ($urandom_range(0, 9) != 0) cnt = sb.planned_len[19:0];
            end else if (sel < 35) op = rpwc_pkg::OP_PLAN_FILL;
            else if (sel < 45) op = rpwc_pkg::OP_FILL_DONE;
            else if (sel < 80) begin
                op = rpwc_pkg::OP_READ;
                span = 2 * sb.ahead_bytes() + 16;
                if (span > CNT_MASK) span = CNT_MASK;
                if ($urandom_range(0, 7) != 0) cnt = 20'($urandom_range(0, span[31:0]));
            end else if (sel < 90) begin
                op = rpwc_pkg::OP_SEEK;
                if ($urandom_range(0, 3) != 0) begin
                    span = sb.win_hi - sb.win_lo + 64;
                    if (span > 32'hFFFF_FFFF) span = 32'hFFFF_FFFF;
                    p = 48'(sb.win_lo + 64'($urandom_range(0, span[31:0])));
                end
            end else if (sel < 97) begin
                op = rpwc_pkg::OP_REPOSITION;
                if ($urandom_range(0, 1) == 0) p = {16'h0, p[31:0]};
            end else op = 3'($urandom_range(5, 7));
            send_op(op, p, cnt, 1'($urandom_range(0, 1)));
            if (op <= rpwc_pkg::OP_REPOSITION) done++;
        end
    endtask

    // result channel: random backpressure plus one long hold-off
    initial begin
        i_out_ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!stall_done && sb.checked >= 150) begin
                stall_done = 1;
                i_out_ready = 0;
                repeat (400) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_ready = 0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            i_out_ready = 1;
        end
    end

    always @(posedge i_clk) begin
        t_window_result r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            r.ring_pos = o_ring_pos; r.length = o_length; r.wrap_copy = o_wrap_copy;
            r.seek_needed = o_seek_needed; r.seek_pos = o_seek_pos;
            r.skip_bytes = o_skip_bytes; r.stop_status = o_stop_status;
            r.fill_level = o_fill_level; r.last = o_last;
            sb.check_result(r);
        end
    end

    initial begin
        sb = new();
        calm = 0; stall_done = 0;
        i_rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        i_in_valid = 0; i_operation = rpwc_pkg::OP_PLAN_FILL; i_position = 0;
        i_count = 0; i_at_end = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: reset settings, edges of the fields, every operation
        send_op(rpwc_pkg::OP_REPOSITION, 0, 0, 0);
        send_op(rpwc_pkg::OP_PLAN_FILL, 0, 0, 0);
        send_op(rpwc_pkg::OP_FILL_DONE, 0, sb.planned_len[19:0], 0);
        send_op(rpwc_pkg::OP_READ, 0, 0, 0);
        send_op(rpwc_pkg::OP_READ, 0, 100, 0);
        send_op(rpwc_pkg::OP_READ, 0, 20'hFFFFF, 0);
        send_op(rpwc_pkg::OP_PLAN_FILL, 0, 0, 0);
        send_op(rpwc_pkg::OP_FILL_DONE, 0, 0, 0);
        send_op(rpwc_pkg::OP_READ, 0, 20, 0);
        send_op(rpwc_pkg::OP_SEEK, 48'hFFFF_FFFF_FFFF, 0, 0);
        send_op(rpwc_pkg::OP_SEEK, 48'd12345, 0, 0);
        send_op(rpwc_pkg::OP_PLAN_FILL, 0, 0, 0);
        send_op(rpwc_pkg::OP_REPOSITION, 48'hFFFF_FFFF_FF00, 0, 1);
        send_op(rpwc_pkg::OP_READ, 0, 5, 0);
        send_op(rpwc_pkg::OP_PLAN_FILL, 0, 0, 0);
        send_op(rpwc_pkg::OP_FILL_DONE, 0, 20'hFFFFF, 0);
        send_op(rpwc_pkg::OP_READ, 0, 20'hFFFFF, 0);
        send_op(3'd5, 48'hAAAA_AAAA_AAAA, 20'h55555, 1);
        send_op(3'd6, 0, 0, 0);
        send_op(3'd7, 48'hFFFF_FFFF_FFFF, 20'hFFFFF, 1);
        send_op(rpwc_pkg::OP_SEEK, 48'h0000_0100_0000, 0, 0);
        send_op(rpwc_pkg::OP_PLAN_FILL, 0, 0, 0);
        send_op(rpwc_pkg::OP_REPOSITION, 0, 0, 0);

        random_ops(300);
        // sender waits for every result before going on
        drain();
        random_ops(100);

        set_phase(64, 1, 0, 0, 0, 1);
        random_ops(200);
        set_phase(4096, 512, 1024, 512, 2048, 1000);
        random_ops(250);
        set_phase(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'h000F_FFFF);
        random_ops(150);
        set_phase(131072, 65536, 65536, 32'hFFFF_FFFF, 0, 4096);
        random_ops(80);
        set_phase(8192, 4096, 100, 4096, 1000, 3000);
        random_ops(120);
        calm = 1;
        random_ops(120);

        drain();
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
